>>> rtl/core/cpso_pkg.sv
// Shared constants and the command type of the convex polygon overlap test.
package cpso_pkg;

   localparam int VERTEX_BITS = 16;
   localparam int PIPE_DRAIN  = 3;
   localparam int DRAIN_BITS  = 2;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic ld_vi;
      logic ld_axis;
      logic proj_valid;
      logic proj_first;
      logic proj_poly;
   } cpso_cmd_type;

endpackage

>>> rtl/core/cpso_if.sv
// Handshake channels for vertex requests and overlap responses.
interface cpso_req_if import cpso_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic                          which_polygon;
   logic signed [VERTEX_BITS-1:0] vertex_x;
   logic signed [VERTEX_BITS-1:0] vertex_y;
   logic                          last_vertex;

   modport source (output valid, output which_polygon, output vertex_x, output vertex_y,
                   output last_vertex, input ready);
   modport sink (input valid, input which_polygon, input vertex_x, input vertex_y,
                 input last_vertex, output ready);
endinterface

interface cpso_rsp_if;
   logic valid;
   logic ready;
   logic separated;
   logic overflowed;

   modport source (output valid, output separated, output overflowed, input ready);
   modport sink (input valid, input separated, input overflowed, output ready);
endinterface

>>> rtl/core/cpso_datapath.sv
// Vertex memory, edge normal, projection pipeline and interval compare.
module cpso_datapath import cpso_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16,
   localparam int IW = $clog2(MAX_VERTICES),
   localparam int AW = IW + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpso_cmd_type                  cmd,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [AW-1:0]                 rd_addr,
   input  logic signed [VERTEX_BITS-1:0] vertex_x,
   input  logic signed [VERTEX_BITS-1:0] vertex_y,
   output logic                          sep_axis
);

   localparam int CB = COORD_BITS;
   localparam int DW = CB + 1;
   localparam int PW = 2 * CB + 1;
   localparam int SW = 2 * CB + 2;
   localparam int MEM_DEPTH = 2 ** AW;

   logic [2*CB-1:0]   vertex_mem_ff [MEM_DEPTH];
   logic [2*CB-1:0]   rd_data_ff;
   logic signed [CB-1:0] wr_x, wr_y, rd_x, rd_y;

   logic signed [CB-1:0] vi_x_ff, vi_x_in, vi_y_ff, vi_y_in;
   logic signed [DW-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [PW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [SW-1:0] a_lo_ff, a_lo_in, a_hi_ff, a_hi_in;
   logic signed [SW-1:0] b_lo_ff, b_lo_in, b_hi_ff, b_hi_in;

   logic s0_valid_ff, s0_first_ff, s0_poly_ff;
   logic s1_valid_ff, s1_first_ff, s1_poly_ff;
   logic s2_valid_ff, s2_first_ff, s2_poly_ff;

   generate
      if (COORD_BITS <= VERTEX_BITS) begin : g_narrow
         assign wr_x = signed'(vertex_x[CB-1:0]);
         assign wr_y = signed'(vertex_y[CB-1:0]);
      end else begin : g_wide
         assign wr_x = signed'({{(CB-VERTEX_BITS){1'b0}}, vertex_x});
         assign wr_y = signed'({{(CB-VERTEX_BITS){1'b0}}, vertex_y});
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         vertex_mem_ff[wr_addr] <= {wr_y, wr_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= vertex_mem_ff[rd_addr];
      end
   end

   assign rd_x = signed'(rd_data_ff[CB-1:0]);
   assign rd_y = signed'(rd_data_ff[2*CB-1:CB]);

   always_comb begin
      vi_x_in = cmd.ld_vi ? rd_x : vi_x_ff;
      vi_y_in = cmd.ld_vi ? rd_y : vi_y_ff;
      ax_in   = cmd.ld_axis ? (DW'(vi_y_ff) - DW'(rd_y)) : ax_ff;
      ay_in   = cmd.ld_axis ? (DW'(rd_x) - DW'(vi_x_ff)) : ay_ff;
      px_in   = PW'(ax_ff) * PW'(rd_x);
      py_in   = PW'(ay_ff) * PW'(rd_y);
      sum_in  = SW'(px_ff) + SW'(py_ff);
   end

   always_comb begin
      a_lo_in = a_lo_ff;
      a_hi_in = a_hi_ff;
      b_lo_in = b_lo_ff;
      b_hi_in = b_hi_ff;
      if (s2_valid_ff) begin
         if (!s2_poly_ff) begin
            a_lo_in = (s2_first_ff || sum_ff < a_lo_ff) ? sum_ff : a_lo_ff;
            a_hi_in = (s2_first_ff || sum_ff > a_hi_ff) ? sum_ff : a_hi_ff;
         end else begin
            b_lo_in = (s2_first_ff || sum_ff < b_lo_ff) ? sum_ff : b_lo_ff;
            b_hi_in = (s2_first_ff || sum_ff > b_hi_ff) ? sum_ff : b_hi_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      vi_x_ff <= vi_x_in;
      vi_y_ff <= vi_y_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      sum_ff  <= sum_in;
      a_lo_ff <= a_lo_in;
      a_hi_ff <= a_hi_in;
      b_lo_ff <= b_lo_in;
      b_hi_ff <= b_hi_in;
      s0_first_ff <= cmd.proj_first;
      s0_poly_ff  <= cmd.proj_poly;
      s1_first_ff <= s0_first_ff;
      s1_poly_ff  <= s0_poly_ff;
      s2_first_ff <= s1_first_ff;
      s2_poly_ff  <= s1_poly_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= cmd.proj_valid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign sep_axis = !((a_lo_ff <= b_hi_ff) && (b_lo_ff <= a_hi_ff));

endmodule

>>> rtl/core/cpso_ctrl.sv
// Sequencer for vertex loading, the axis loop and the response register.
module cpso_ctrl import cpso_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   localparam int IW = $clog2(MAX_VERTICES),
   localparam int AW = IW + 1
) (
   input  logic         clock,
   input  logic         reset,
   cpso_req_if.sink     req_chan,
   cpso_rsp_if.source   rsp_chan,
   output cpso_cmd_type cmd,
   output logic [AW-1:0] wr_addr,
   output logic [AW-1:0] rd_addr,
   input  logic         sep_axis
);

   localparam int CNTW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_START  = 9'b000000010,
      ST_EDGE0  = 9'b000000100,
      ST_EDGE1  = 9'b000001000,
      ST_AXIS   = 9'b000010000,
      ST_PROJ   = 9'b000100000,
      ST_DRAIN  = 9'b001000000,
      ST_CHECK  = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [CNTW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic drop_ff, drop_in;
   logic ep_ff, ep_in, p_ff, p_in;
   logic [IW-1:0] i_ff, i_in, k_ff, k_in;
   logic [DRAIN_BITS-1:0] drain_ff, drain_in;
   logic sep_ff, sep_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_sep_ff, rsp_sep_in, rsp_ovf_ff, rsp_ovf_in;

   logic accept, to_b, sel_full, rsp_free;
   logic [CNTW-1:0] sel_cnt, n_ep, n_p, i_next, k_next;
   logic [IW-1:0] j_idx;

   assign accept   = req_chan.valid && req_chan.ready;
   assign to_b     = req_chan.which_polygon;
   assign sel_cnt  = to_b ? cnt_b_ff : cnt_a_ff;
   assign sel_full = (sel_cnt >= CNTW'(MAX_VERTICES));
   assign n_ep     = ep_ff ? cnt_b_ff : cnt_a_ff;
   assign n_p      = p_ff ? cnt_b_ff : cnt_a_ff;
   assign i_next   = CNTW'(i_ff) + CNTW'(1);
   assign k_next   = CNTW'(k_ff) + CNTW'(1);
   assign j_idx    = (i_next < n_ep) ? i_next[IW-1:0] : '0;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.separated  = rsp_sep_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      drop_in      = drop_ff;
      ep_in        = ep_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      drain_in     = drain_ff;
      sep_in       = sep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_sep_in   = rsp_sep_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      cmd          = '0;
      wr_addr      = {to_b, sel_cnt[IW-1:0]};
      rd_addr      = {ep_ff, i_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (sel_full) begin
                  drop_in = 1'b1;
               end else begin
                  cmd.wr_en = 1'b1;
                  if (to_b) begin
                     cnt_b_in = cnt_b_ff + CNTW'(1);
                  end else begin
                     cnt_a_in = cnt_a_ff + CNTW'(1);
                  end
               end
               if (to_b && req_chan.last_vertex) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            ep_in = 1'b0;
            i_in  = '0;
            if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
               sep_in   = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_EDGE0;
            end
         end
         ST_EDGE0: begin
            cmd.rd_en = 1'b1;
            rd_addr   = {ep_ff, i_ff};
            state_in  = ST_EDGE1;
         end
         ST_EDGE1: begin
            cmd.rd_en = 1'b1;
            cmd.ld_vi = 1'b1;
            rd_addr   = {ep_ff, j_idx};
            state_in  = ST_AXIS;
         end
         ST_AXIS: begin
            cmd.ld_axis = 1'b1;
            p_in        = 1'b0;
            k_in        = '0;
            state_in    = ST_PROJ;
         end
         ST_PROJ: begin
            cmd.rd_en      = 1'b1;
            cmd.proj_valid = 1'b1;
            cmd.proj_first = (k_ff == '0);
            cmd.proj_poly  = p_ff;
            rd_addr        = {p_ff, k_ff};
            if (k_next == n_p) begin
               k_in = '0;
               if (!p_ff) begin
                  p_in = 1'b1;
               end else begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end
            end else begin
               k_in = k_next[IW-1:0];
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_BITS'(PIPE_DRAIN - 1)) begin
               state_in = ST_CHECK;
            end else begin
               drain_in = drain_ff + DRAIN_BITS'(1);
            end
         end
         ST_CHECK: begin
            if (sep_axis) begin
               sep_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (i_next == n_ep) begin
               i_in = '0;
               if (!ep_ff) begin
                  ep_in    = 1'b1;
                  state_in = ST_EDGE0;
               end else begin
                  sep_in   = 1'b0;
                  state_in = ST_FINISH;
               end
            end else begin
               i_in     = i_next[IW-1:0];
               state_in = ST_EDGE0;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sep_in   = sep_ff;
               rsp_ovf_in   = drop_ff;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               drop_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff      <= ep_in;
      p_ff       <= p_in;
      i_ff       <= i_in;
      k_ff       <= k_in;
      drain_ff   <= drain_in;
      sep_ff     <= sep_in;
      rsp_sep_ff <= rsp_sep_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_a_ff <= CNTW'(MAX_VERTICES)) && (cnt_b_ff <= CNTW'(MAX_VERTICES)))
      else $error("Vertex count exceeds store capacity.");

   a_cnt_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_FINISH)
      |=> $stable(cnt_a_ff) && $stable(cnt_b_ff))
      else $error("Vertex counts changed while the test was running.");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("Response loaded outside the finish step.");

   a_proj_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROJ) |-> (CNTW'(k_ff) < n_p))
      else $error("Projection read beyond the vertex count.");
`endif

endmodule

>>> rtl/core/convex_polygon_sat_overlap.sv
// Top level of the separating axis overlap test for two convex polygons.
// Vertices arrive one per transfer, polygon A with which_polygon low and B with it high, and
// each vertex is written to the vertex memory; up to MAX_VERTICES per polygon are kept and
// extra ones are dropped and reported through overflowed. The transfer that carries B's last
// vertex starts the test, and no vertex is taken until its response has been loaded into the
// output register. The test walks the edge normals of A and then of B, stopping at the first
// separating axis. Each axis is processed step by step, since the vertex memory has one read
// port and every vertex projection is one read: two reads for the edge, forming the normal,
// one read per vertex, draining the multiplier and adder pipeline, and one compare.
// A response still waiting on rsp_chan does not block loading the next pair.
module convex_polygon_sat_overlap import cpso_pkg::*; #(
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   cpso_req_if.sink   req_chan,
   cpso_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MAX_VERTICES) + 1;

   cpso_cmd_type  cmd;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          sep_axis;

   cpso_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .sep_axis (sep_axis)
   );

   cpso_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .vertex_x (req_chan.vertex_x),
      .vertex_y (req_chan.vertex_y),
      .sep_axis (sep_axis)
   );

endmodule
